### hdl/mcsc_pkg.sv
package mcsc_pkg;

   localparam int LenFirst  = 19;
   localparam int LenSecond = 22;
   localparam int LenThird  = 23;
   localparam int KeyBits   = 64;

   localparam logic CmdLoad    = 1'b0;
   localparam logic CmdEncrypt = 1'b1;

   typedef struct packed {
      logic [LenFirst-1:0]  first;
      logic [LenSecond-1:0] second;
      logic [LenThird-1:0]  third;
   } lfsr_state_type;

   // Element i of each register takes key bit (offset + i), and key bit 0 is the key's MSB.
   function automatic lfsr_state_type load_from_key(input logic [KeyBits-1:0] key);
      lfsr_state_type st;
      for (int i = 0; i < LenFirst; i++) begin
         st.first[i] = key[KeyBits-1-i];
      end
      for (int j = 0; j < LenSecond; j++) begin
         st.second[j] = key[KeyBits-1-LenFirst-j];
      end
      for (int k = 0; k < LenThird; k++) begin
         st.third[k] = key[KeyBits-1-LenFirst-LenSecond-k];
      end
      return st;
   endfunction

endpackage

### hdl/majority_clocked_lfsr_stream_cipher_top.sv
// An accepted beat is held in the input register, then moves to the result register.
// Throughput: one beat per cycle, unless rsp_stall holds a waiting result.
// Input and result registers hold one beat each, so one beat is taken while a result waits.
// Reset is synchronous and active high; it clears the key, the LFSRs and both valid flags.
module majority_clocked_lfsr_stream_cipher_top
   import mcsc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cmd,
   input  logic               req_text_bit,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_cipher_bit,
   output logic               rsp_stream_bit,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [KeyBits-1:0] csr_cipher_key
);

   logic               in_valid_ff;
   logic               in_valid_in;
   logic               in_cmd_ff;
   logic               in_text_ff;
   logic               out_valid_ff;
   logic               out_valid_in;
   logic               out_cipher_ff;
   logic               out_stream_ff;
   logic [KeyBits-1:0] key_ff;
   lfsr_state_type     lfsr_ff;
   lfsr_state_type     lfsr_in;
   logic               step_cipher;
   logic               step_stream;
   logic               advance;
   logic               req_take;

   mcsc_step u_step (
      .state_cur  (lfsr_ff),
      .cmd        (in_cmd_ff),
      .text_bit   (in_text_ff),
      .cipher_key (key_ff),
      .state_nxt  (lfsr_in),
      .cipher_bit (step_cipher),
      .stream_bit (step_stream)
   );

   assign advance   = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   assign in_valid_in  = req_take | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         key_ff       <= '0;
         lfsr_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid & csr_ready) begin
            key_ff <= csr_cipher_key;
         end
         if (advance) begin
            lfsr_ff <= lfsr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff  <= req_cmd;
         in_text_ff <= req_text_bit;
      end
      if (advance) begin
         out_cipher_ff <= step_cipher;
         out_stream_ff <= step_stream;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_cipher_bit = out_cipher_ff;
   assign rsp_stream_bit = out_stream_ff;

endmodule

### hdl/mcsc_step.sv
module mcsc_step
   import mcsc_pkg::*;
(
   input  lfsr_state_type     state_cur,
   input  logic               cmd,
   input  logic               text_bit,
   input  logic [KeyBits-1:0] cipher_key,
   output lfsr_state_type     state_nxt,
   output logic               cipher_bit,
   output logic               stream_bit
);

   logic           clk_a;
   logic           clk_b;
   logic           clk_c;
   logic           vote;
   logic           fb_a;
   logic           fb_b;
   logic           fb_c;
   lfsr_state_type shifted;
   logic           ks;

   always_comb begin
      clk_a = state_cur.first[8];
      clk_b = state_cur.second[10];
      clk_c = state_cur.third[10];
      vote  = (clk_a & clk_b) | (clk_a & clk_c) | (clk_b & clk_c);

      fb_a = state_cur.first[13] ^ state_cur.first[16] ^
             state_cur.first[17] ^ state_cur.first[18];
      fb_b = state_cur.second[20] ^ state_cur.second[21];
      fb_c = state_cur.third[7] ^ state_cur.third[20] ^
             state_cur.third[21] ^ state_cur.third[22];

      shifted = state_cur;
      if (clk_a == vote) begin
         shifted.first = {state_cur.first[LenFirst-2:0], fb_a};
      end
      if (clk_b == vote) begin
         shifted.second = {state_cur.second[LenSecond-2:0], fb_b};
      end
      if (clk_c == vote) begin
         shifted.third = {state_cur.third[LenThird-2:0], fb_c};
      end

      ks = shifted.first[LenFirst-1] ^ shifted.second[LenSecond-1] ^
           shifted.third[LenThird-1];

      if (cmd == CmdLoad) begin
         state_nxt  = load_from_key(cipher_key);
         cipher_bit = 1'b0;
         stream_bit = 1'b0;
      end else begin
         state_nxt  = shifted;
         cipher_bit = text_bit ^ ks;
         stream_bit = ks;
      end
   end

endmodule

### tb/keystream_checker.sv
`timescale 1ns / 100ps

module keystream_checker
   import mcsc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_cmd,
   input  logic               req_text_bit,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_cipher_bit,
   input  logic               rsp_stream_bit,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [KeyBits-1:0] csr_cipher_key,
   output int                 outstanding,
   output int                 error_count
);

   localparam logic [LenFirst-1:0]  TapsFirst  = 19'h72000;
   localparam logic [LenSecond-1:0] TapsSecond = 22'h300000;
   localparam logic [LenThird-1:0]  TapsThird  = 23'h700080;
   localparam int ClockFirst  = 8;
   localparam int ClockSecond = 10;
   localparam int ClockThird  = 10;

   typedef struct packed {
      logic cipher_bit;
      logic stream_bit;
   } cipher_result_type;

   logic [KeyBits-1:0] key_now = '0;
   lfsr_state_type     lfsr_now = '0;
   cipher_result_type  expected_bits[$];
   int                 mismatches = 0;

   function automatic cipher_result_type next_keystream(logic cmd, logic text_bit);
      cipher_result_type res;
      logic c1, c2, c3, vote, ks;
      res = '0;
      if (cmd == CmdLoad) begin
         for (int i = 0; i < LenFirst; i++) begin
            lfsr_now.first[i] = key_now[KeyBits-1-i];
         end
         for (int j = 0; j < LenSecond; j++) begin
            lfsr_now.second[j] = key_now[KeyBits-1-LenFirst-j];
         end
         for (int k = 0; k < LenThird; k++) begin
            lfsr_now.third[k] = key_now[KeyBits-1-LenFirst-LenSecond-k];
         end
      end else begin
         c1 = lfsr_now.first[ClockFirst];
         c2 = lfsr_now.second[ClockSecond];
         c3 = lfsr_now.third[ClockThird];
         vote = (c1 & c2) | (c1 & c3) | (c2 & c3);
         if (c1 == vote) begin
            lfsr_now.first = {lfsr_now.first[LenFirst-2:0], ^(lfsr_now.first & TapsFirst)};
         end
         if (c2 == vote) begin
            lfsr_now.second = {lfsr_now.second[LenSecond-2:0],
                               ^(lfsr_now.second & TapsSecond)};
         end
         if (c3 == vote) begin
            lfsr_now.third = {lfsr_now.third[LenThird-2:0], ^(lfsr_now.third & TapsThird)};
         end
         ks = lfsr_now.first[LenFirst-1] ^ lfsr_now.second[LenSecond-1] ^
              lfsr_now.third[LenThird-1];
         res.stream_bit = ks;
         res.cipher_bit = text_bit ^ ks;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      cipher_result_type got, want;
      if (reset) begin
         key_now = '0;
         lfsr_now = '0;
         expected_bits.delete();
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            got.cipher_bit = rsp_cipher_bit;
            got.stream_bit = rsp_stream_bit;
            if (expected_bits.size() == 0) begin
               $display("%0t: extra result beat, expected none, actual %b %b",
                        $time, got.cipher_bit, got.stream_bit);
               mismatches++;
            end else begin
               want = expected_bits.pop_front();
               if (got.cipher_bit !== want.cipher_bit) begin
                  $display("%0t: cipher_bit mismatch, expected %b actual %b",
                           $time, want.cipher_bit, got.cipher_bit);
                  mismatches++;
               end
               if (got.stream_bit !== want.stream_bit) begin
                  $display("%0t: stream_bit mismatch, expected %b actual %b",
                           $time, want.stream_bit, got.stream_bit);
                  mismatches++;
               end
            end
         end
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            expected_bits.insert(expected_bits.size(), next_keystream(req_cmd, req_text_bit));
         end
         if (csr_valid === 1'b1 && csr_ready === 1'b1) begin
            key_now = csr_cipher_key;
         end
      end
      outstanding <= expected_bits.size();
      error_count <= mismatches;
   end

endmodule

### tb/majority_clocked_lfsr_stream_cipher_top_test.sv
`timescale 1ns / 100ps

module majority_clocked_lfsr_stream_cipher_top_test
   import mcsc_pkg::*;
();

   localparam logic [KeyBits-1:0] KeyOnes = '1;
   localparam logic [KeyBits-1:0] KeyZero = '0;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_cmd = CmdLoad;
   logic               req_text_bit = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_cipher_bit;
   logic               rsp_stream_bit;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [KeyBits-1:0] csr_cipher_key = '0;

   int outstanding;
   int error_count;
   int send_idle_pct = 14;
   int recv_stall_pct = 61;

   majority_clocked_lfsr_stream_cipher_top uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_text_bit   (req_text_bit),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cipher_bit (rsp_cipher_bit),
      .rsp_stream_bit (rsp_stream_bit),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_cipher_key (csr_cipher_key)
   );

   keystream_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_text_bit   (req_text_bit),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cipher_bit (rsp_cipher_bit),
      .rsp_stream_bit (rsp_stream_bit),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_cipher_key (csr_cipher_key),
      .outstanding    (outstanding),
      .error_count    (error_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   initial begin
      #5_000_000;
      $display("majority_clocked_lfsr_stream_cipher_top_test: FAIL");
      $finish;
   end

   task automatic send_beat(logic cmd, logic text_bit);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_text_bit <= text_bit;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_key(logic [KeyBits-1:0] key);
      csr_valid <= 1'b1;
      csr_cipher_key <= key;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic run_segment(int count);
      logic [KeyBits-1:0] key;
      wait_drained();
      key = {$urandom, $urandom};
      if ($urandom_range(9) == 0) begin
         key = KeyOnes;
      end else if ($urandom_range(9) == 0) begin
         key = KeyZero;
      end
      write_key(key);
      send_beat(CmdLoad, 1'($urandom_range(1)));
      repeat (count - 1) begin
         if ($urandom_range(99) < 3) begin
            send_beat(CmdLoad, 1'($urandom_range(1)));
         end else begin
            send_beat(CmdEncrypt, 1'($urandom_range(1)));
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Encrypting before any load runs on the all-zero registers.
      send_beat(CmdEncrypt, 1'b0);
      send_beat(CmdEncrypt, 1'b1);

      wait_drained();
      write_key(KeyOnes);
      send_beat(CmdLoad, 1'b1);
      send_beat(CmdEncrypt, 1'b1);
      send_beat(CmdEncrypt, 1'b0);
      send_beat(CmdEncrypt, 1'b0);

      wait_drained();
      write_key(KeyZero);
      send_beat(CmdLoad, 1'b0);
      send_beat(CmdEncrypt, 1'b1);
      send_beat(CmdEncrypt, 1'b0);

      wait_drained();
      write_key(64'h8000_0000_0000_0001);
      send_beat(CmdLoad, 1'b0);
      send_beat(CmdEncrypt, 1'b1);
      send_beat(CmdEncrypt, 1'b1);
      send_beat(CmdEncrypt, 1'b1);
      send_beat(CmdLoad, 1'b1);
      send_beat(CmdEncrypt, 1'b0);

      wait_drained();
      write_key({$urandom, $urandom});
      send_beat(CmdLoad, 1'b0);
      repeat (4) send_beat(CmdEncrypt, 1'($urandom_range(1)));
      send_beat(CmdLoad, 1'b0);
      send_beat(CmdLoad, 1'b1);
      send_beat(CmdEncrypt, 1'b1);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 14;
               recv_stall_pct = 61;
            end
            1: begin
               send_idle_pct = 61;
               recv_stall_pct = 14;
            end
            default: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
         endcase
         repeat (4) run_segment(121);
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("majority_clocked_lfsr_stream_cipher_top_test: PASS");
      end else begin
         $display("majority_clocked_lfsr_stream_cipher_top_test: FAIL");
      end
      $finish;
   end

endmodule
